FILE: src/rolling_window_polynomial_hash_defines.svh
// Assertion macros for the rolling window hash
`ifndef ROLLING_WINDOW_POLYNOMIAL_HASH_DEFINES_SVH
`define ROLLING_WINDOW_POLYNOMIAL_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
`define RWPH_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define RWPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RWPH_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define RWPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/rwph_pkg.sv
package rwph_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_op;

    localparam t_mode MODE_APPEND = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_SLIDE  = 2'd2;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    localparam t_op OP_RED = 2'd0;
    localparam t_op OP_POW = 2'd1;
    localparam t_op OP_APP = 2'd2;
    localparam t_op OP_REM = 2'd3;

    localparam logic CFG_BASE    = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    localparam logic [31:0] BASE_RESET    = 32'd256;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage

FILE: src/rolling_window_polynomial_hash.sv
// Rolling polynomial hash over a window of up to MAX_WINDOW bytes. Each input word carries a
// mode (append, remove oldest, slide) and a byte, and yields one output word with the hash,
// the window length and a status. All modular multiplication runs on one shared unit: a 32x32
// multiply-add step (S_MUL) followed by a bit-serial restoring remainder of the 64-bit
// product against the modulus (S_DIV). A slide runs an append and then a remove; rejected
// or no-op words go straight to the result. After reset and after every configuration
// write the block reduces the hash and rebuilds its power table, one multiply-reduce per
// entry, with o_ready low meanwhile.
`include "rolling_window_polynomial_hash_defines.svh"

module rolling_window_polynomial_hash #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [31:0]                        i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_mode,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [31:0]                        o_hash_value,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    o_window_length,
    output logic [1:0]                         o_status
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = $clog2(MAX_WINDOW);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WINDOW);
    localparam logic [CW:0]   WRAP    = (CW+1)'(MAX_WINDOW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RED  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_POST = 4'd4;
    localparam logic [3:0] S_RRD  = 4'd5;
    localparam logic [3:0] S_RRD2 = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]            r_state;
    logic [31:0]           r_base;
    logic [31:0]           r_modulus;
    logic [31:0]           r_hash;
    logic [CW-1:0]         r_count;
    logic [PW-1:0]         r_oldest;
    logic [CW-1:0]         r_pk;
    rwph_pkg::t_mode       r_mode;
    rwph_pkg::t_status     r_status;
    rwph_pkg::t_op         r_op;
    logic [31:0]           r_opa;
    logic [31:0]           r_opb;
    logic [7:0]            r_opc;
    logic [63:0]           r_prod;
    logic [31:0]           r_rem;
    logic [5:0]            r_bit;
    logic [7:0]            r_rd_byte;
    logic [31:0]           r_rd_pow;
    logic                  r_o_valid;
    logic [31:0]           r_o_hash;
    logic [CW-1:0]         r_o_len;
    rwph_pkg::t_status     r_o_status;

    logic [7:0]            r_store [MAX_WINDOW];
    logic [31:0]           r_pow   [MAX_WINDOW+1];

    logic [31:0]           w_m;
    logic [63:0]           w_prod;
    logic [32:0]           w_trial;
    logic [32:0]           w_trial_sub;
    logic [32:0]           w_hsub;
    logic [CW:0]           w_slot_sum;
    logic [PW-1:0]         w_slot;
    logic [PW-1:0]         w_oldest_inc;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_st_we;
    logic                  w_pw_we;
    logic [CW-1:0]         w_pw_addr;
    logic [31:0]           w_pw_data;

    assign w_m        = (r_modulus < 32'd2) ? 32'd2 : r_modulus;
    assign w_prod     = 64'(r_opa) * 64'(r_opb) + 64'(r_opc);
    assign w_trial    = {r_rem, r_prod[63]};
    assign w_trial_sub = w_trial - {1'b0, w_m};
    assign w_hsub     = (r_rem > r_hash) ? ({1'b0, r_hash} + {1'b0, w_m} - {1'b0, r_rem})
                                         : ({1'b0, r_hash} - {1'b0, r_rem});
    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_count >= CNT_MAX);
    assign w_empty    = (r_count == '0);
    assign w_slot_sum = (CW+1)'(r_oldest) + (CW+1)'(r_count);
    assign w_slot     = (w_slot_sum >= WRAP) ? PW'(w_slot_sum - WRAP) : PW'(w_slot_sum);
    assign w_oldest_inc = (32'(r_oldest) == MAX_WINDOW - 1) ? '0 : r_oldest + PW'(1);

    assign w_st_we = w_accept && !w_full &&
                     (i_mode == rwph_pkg::MODE_APPEND || i_mode == rwph_pkg::MODE_SLIDE);
    assign w_pw_we   = (r_state == S_POST) && (r_op == rwph_pkg::OP_RED || r_op == rwph_pkg::OP_POW);
    assign w_pw_addr = (r_op == rwph_pkg::OP_RED) ? '0 : r_pk;
    assign w_pw_data = (r_op == rwph_pkg::OP_RED) ? 32'd1 : r_rem;

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_store[w_slot] <= i_data_byte;
        end
        if (w_pw_we) begin
            r_pow[w_pw_addr] <= w_pw_data;
        end
        r_rd_byte <= r_store[r_oldest];
        r_rd_pow  <= r_pow[r_count - CW'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RED;
            r_base    <= rwph_pkg::BASE_RESET;
            r_modulus <= rwph_pkg::MODULUS_RESET;
            r_hash    <= '0;
            r_count   <= '0;
            r_oldest  <= '0;
            r_pk      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == rwph_pkg::CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_modulus <= i_cfg_data;
                end
                r_state <= S_RED;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (w_accept) begin
                            r_mode   <= i_mode;
                            r_status <= rwph_pkg::STAT_OK;
                            r_opa    <= r_hash;
                            r_opb    <= r_base;
                            r_opc    <= i_data_byte;
                            r_op     <= rwph_pkg::OP_APP;
                            case (i_mode)
                                rwph_pkg::MODE_APPEND, rwph_pkg::MODE_SLIDE: begin
                                    if (w_full) begin
                                        r_status <= rwph_pkg::STAT_FULL;
                                        r_state  <= S_FIN;
                                    end else begin
                                        r_count <= r_count + CW'(1);
                                        r_state <= S_MUL;
                                    end
                                end
                                rwph_pkg::MODE_REMOVE: begin
                                    if (w_empty) begin
                                        r_status <= rwph_pkg::STAT_EMPTY;
                                        r_state  <= S_FIN;
                                    end else begin
                                        r_state <= S_RRD;
                                    end
                                end
                                default: r_state <= S_FIN;
                            endcase
                        end
                    end
                    S_RED: begin
                        r_opa   <= r_hash;
                        r_opb   <= 32'd1;
                        r_opc   <= '0;
                        r_op    <= rwph_pkg::OP_RED;
                        r_state <= S_MUL;
                    end
                    S_MUL: begin
                        r_prod  <= w_prod;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                    S_DIV: begin
                        r_rem  <= w_trial_sub[32] ? w_trial[31:0] : w_trial_sub[31:0];
                        r_prod <= {r_prod[62:0], 1'b0};
                        r_bit  <= r_bit + 6'd1;
                        if (r_bit == 6'd63) begin
                            r_state <= S_POST;
                        end
                    end
                    S_POST: begin
                        case (r_op)
                            rwph_pkg::OP_RED: begin
                                r_hash  <= r_rem;
                                r_pk    <= CW'(1);
                                r_opa   <= 32'd1;
                                r_opb   <= r_base;
                                r_opc   <= '0;
                                r_op    <= rwph_pkg::OP_POW;
                                r_state <= S_MUL;
                            end
                            rwph_pkg::OP_POW: begin
                                if (r_pk == CNT_MAX) begin
                                    r_state <= S_IDLE;
                                end else begin
                                    r_pk    <= r_pk + CW'(1);
                                    r_opa   <= r_rem;
                                    r_state <= S_MUL;
                                end
                            end
                            rwph_pkg::OP_APP: begin
                                r_hash  <= r_rem;
                                r_state <= (r_mode == rwph_pkg::MODE_SLIDE) ? S_RRD : S_FIN;
                            end
                            default: begin
                                r_hash   <= w_hsub[31:0];
                                r_oldest <= w_oldest_inc;
                                r_count  <= r_count - CW'(1);
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                    S_RRD: begin
                        r_state <= S_RRD2;
                    end
                    S_RRD2: begin
                        r_opa   <= {24'd0, r_rd_byte};
                        r_opb   <= r_rd_pow;
                        r_opc   <= '0;
                        r_op    <= rwph_pkg::OP_REM;
                        r_state <= S_MUL;
                    end
                    S_FIN: begin
                        if (!r_o_valid || i_ready) begin
                            r_o_hash   <= r_hash;
                            r_o_len    <= r_count;
                            r_o_status <= r_status;
                            r_state    <= S_IDLE;
                        end
                    end
                    default: r_state <= S_RED;
                endcase
            end
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_hash_value    = r_o_hash;
    assign o_window_length = r_o_len;
    assign o_status        = r_o_status;

    `RWPH_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_MAX, "count over window")
    `RWPH_ASSERT_ALWAYS(a_hash_reduced, i_clk, i_rst_n, (r_state != S_IDLE) || (r_hash < w_m), "hash not reduced")
    `RWPH_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_ready, "ready after accept")

endmodule
